// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the NAT translation table.
// Needs nothing else; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(name, clk, rst, cond, conseq) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("implication failed");
`else
`define ASSERT_AT(name, clk, rst, prop)
`define ASSERT_IMPLY(name, clk, rst, cond, conseq)
`endif
`endif

// File: rtl/ntt_pkg.sv
// Types, codes and sizes of the NAT translation table.
// Used by every module of the block except ntt_ram; depends on nothing.
`default_nettype none
package ntt_pkg;
   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int RULE_SLOTS = 8;
   localparam int RULE_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int PORT_BITS = 16;
   localparam int WORD_BITS = 64;
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int WORD_W = PORT_BITS - BIT_W;
   localparam int PORT_WORDS = 1 << WORD_W;

   localparam logic [31:0] RESET_EXT_ADDR = 32'd0;
   localparam logic [15:0] RESET_PORT_LOW = 16'd12345;
   localparam logic [15:0] RESET_PORT_HIGH = 16'd23456;
   localparam logic [15:0] RESET_IDLE_TIMEOUT = 16'd60;

   localparam logic [1:0] OP_PACKET = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_RULE = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] DIR_OUT = 2'd0;
   localparam logic [1:0] DIR_IN = 2'd1;

   localparam logic [1:0] ACT_FORWARD = 2'd0;
   localparam logic [1:0] ACT_ICMP = 2'd1;
   localparam logic [1:0] ACT_DROP = 2'd2;
   localparam logic [1:0] ACT_DONE = 2'd3;

   localparam int FLAG_FIN = 0;
   localparam int FLAG_SYN = 1;
   localparam int FLAG_RST = 2;
   localparam int FLAG_ACK = 3;

   typedef enum logic [1:0] {
      REG_EXT_ADDR, REG_PORT_LOW, REG_PORT_HIGH, REG_IDLE_TIMEOUT
   } reg_type;

   typedef enum logic [2:0] {
      KIND_DONE, KIND_ICMP, KIND_DROP, KIND_TICK, KIND_RULE, KIND_PKT
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_MISS, ST_PSCAN_RD, ST_PSCAN_EV,
      ST_PORT_RD, ST_PORT_WR, ST_TICK_RD, ST_TICK_EV, ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  direction;
      logic        is_tcp;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [3:0]  tcp_flags;
      logic [31:0] seq_end;
      logic [31:0] ack_number;
      logic [2:0]  rule_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] out_src_addr;
      logic [31:0] out_dst_addr;
      logic [15:0] out_src_port;
      logic [15:0] out_dst_port;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic        inbound;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [3:0]  tcp_flags;
      logic [31:0] seq_end;
      logic [31:0] ack_number;
      logic [2:0]  rule_slot;
   } job_type;

   typedef struct packed {
      logic [31:0] remote_addr;
      logic [15:0] peer_port;
      logic [31:0] outside_addr;
      logic [15:0] outside_port;
      logic [31:0] inside_addr;
      logic [15:0] inside_port;
   } key_type;

   typedef struct packed {
      logic [1:0]  fin_bits;
      logic [31:0] inside_seq_end;
      logic [31:0] outside_seq_end;
      logic [31:0] inside_ack;
      logic [31:0] outside_ack;
      logic [31:0] last_seen;
   } track_type;

   typedef struct packed {
      logic [31:0] external_address;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [15:0] idle_timeout;
   } cfg_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } status_type;
endpackage
`default_nettype wire

// File: rtl/nat_tcp_translation_table.sv
// Top level of the TCP NAT translation table: register file, front end, engine.
// Depends on ntt_pkg, ntt_front, ntt_engine and assert_macros.svh.
//
//   channel   ports               carries
//   request   req_valid/stall     req_data (ntt_pkg::req_type)
//   response  rsp_valid/stall     rsp_data (ntt_pkg::rsp_type), one per request
//   config    psel/penable/...    four registers at byte addresses 0, 4, 8, 12
//
// A packet scans the table as the key RAM read port reads one entry a cycle;
// allocating an outbound port then reads the bitmap one 64-port word at a time.
// A tick checks every entry and frees the port of each expired flow.
// After reset a pass clears all 1024 port bitmap words with req_stall held high.
// Two requests queue ahead of the engine; a finished response waits in its register.
`default_nettype none
`include "assert_macros.svh"
module nat_tcp_translation_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ntt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ntt_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   ntt_pkg::cfg_type    cfg_ff, cfg_in;
   ntt_pkg::status_type status;
   ntt_pkg::job_type    q_job;
   ntt_pkg::reg_type    reg_sel;
   logic                q_valid;
   logic                q_pop;

   assign pready = 1'b1;
   assign reg_sel = ntt_pkg::reg_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         ntt_pkg::REG_EXT_ADDR:     prdata = cfg_ff.external_address;
         ntt_pkg::REG_PORT_LOW:     prdata = {16'd0, cfg_ff.port_low};
         ntt_pkg::REG_PORT_HIGH:    prdata = {16'd0, cfg_ff.port_high};
         ntt_pkg::REG_IDLE_TIMEOUT: prdata = {16'd0, cfg_ff.idle_timeout};
         default:                   prdata = '0;
      endcase
      if (psel && penable && pwrite) begin
         unique case (reg_sel)
            ntt_pkg::REG_EXT_ADDR:     cfg_in.external_address = pwdata;
            ntt_pkg::REG_PORT_LOW:     cfg_in.port_low = pwdata[15:0];
            ntt_pkg::REG_PORT_HIGH:    cfg_in.port_high = pwdata[15:0];
            ntt_pkg::REG_IDLE_TIMEOUT: cfg_in.idle_timeout = pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.external_address <= ntt_pkg::RESET_EXT_ADDR;
         cfg_ff.port_low <= ntt_pkg::RESET_PORT_LOW;
         cfg_ff.port_high <= ntt_pkg::RESET_PORT_HIGH;
         cfg_ff.idle_timeout <= ntt_pkg::RESET_IDLE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ntt_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .status(status), .q_pop(q_pop), .q_valid(q_valid), .q_job(q_job)
   );

   ntt_engine u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_job(q_job), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .status(status)
   );

   `ASSERT_IMPLY(a_clear_stalls, clock, reset, status.clearing, req_stall)
   `ASSERT_IMPLY(a_clear_no_rsp, clock, reset, status.clearing, !rsp_valid)
   `ASSERT_IMPLY(a_clear_ends_idle, clock, reset, $fell(status.clearing), !status.busy)
endmodule
`default_nettype wire

// File: rtl/ntt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used for the mapping table and the port bitmap.
`default_nettype none
module ntt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/ntt_front.sv
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on ntt_pkg.
`default_nettype none
module ntt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ntt_pkg::req_type    req_data,
   input  ntt_pkg::status_type status,
   input  logic                q_pop,
   output logic                q_valid,
   output ntt_pkg::job_type    q_job
);
   ntt_pkg::job_type entry_ff [2];
   ntt_pkg::job_type job;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;

   always_comb begin
      job.inbound = (req_data.direction == ntt_pkg::DIR_IN);
      job.src_addr = req_data.src_addr;
      job.dst_addr = req_data.dst_addr;
      job.src_port = req_data.src_port;
      job.dst_port = req_data.dst_port;
      job.tcp_flags = req_data.tcp_flags;
      job.seq_end = req_data.seq_end;
      job.ack_number = req_data.ack_number;
      job.rule_slot = req_data.rule_slot;
      unique case (req_data.op)
         ntt_pkg::OP_TICK: job.kind = ntt_pkg::KIND_TICK;
         ntt_pkg::OP_RULE: job.kind = ntt_pkg::KIND_RULE;
         ntt_pkg::OP_PACKET: begin
            if (req_data.direction != ntt_pkg::DIR_OUT && req_data.direction != ntt_pkg::DIR_IN)
               job.kind = ntt_pkg::KIND_ICMP;
            else if (!req_data.is_tcp)
               job.kind = ntt_pkg::KIND_DROP;
            else
               job.kind = ntt_pkg::KIND_PKT;
         end
         default: job.kind = ntt_pkg::KIND_DONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2) || status.clearing;
   assign push = req_valid && !req_stall;
   assign q_valid = (count_ff != 2'd0);
   assign q_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (q_pop && q_valid) ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/ntt_engine.sv
// Engine: runs queued jobs against the mapping table, port bitmap and rules.
// Depends on ntt_pkg and ntt_ram.
`default_nettype none
module ntt_engine (
   input  logic                clock,
   input  logic                reset,
   input  ntt_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  ntt_pkg::job_type    q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ntt_pkg::rsp_type    rsp_data,
   output ntt_pkg::status_type status
);
   localparam int N = ntt_pkg::TABLE_ENTRIES;
   localparam int IW = ntt_pkg::IDX_W;
   localparam int WB = ntt_pkg::WORD_BITS;
   localparam int BW = ntt_pkg::BIT_W;
   localparam int WW = ntt_pkg::WORD_W;
   localparam int PB = ntt_pkg::PORT_BITS;

   ntt_pkg::state_type state_ff, state_in;
   ntt_pkg::job_type   job_ff, job_in;
   logic [IW:0]        idx_ff, idx_in;
   logic               cmp_ff, cmp_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               free_ff, free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic [PB-1:0]      port_ff, port_in;
   logic               set_ff, set_in;
   logic [WW-1:0]      word_ff, word_in;
   logic [WW-1:0]      clr_ff, clr_in;
   ntt_pkg::rsp_type   res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ntt_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [N-1:0]       valid_ff, valid_in;
   logic [31:0]        seconds_ff, seconds_in;
   logic [ntt_pkg::RULE_SLOTS-1:0] rule_valid_ff, rule_valid_in;
   logic [31:0]        rule_out_addr_ff [ntt_pkg::RULE_SLOTS];
   logic [15:0]        rule_out_port_ff [ntt_pkg::RULE_SLOTS];
   logic [31:0]        rule_in_addr_ff [ntt_pkg::RULE_SLOTS];
   logic [15:0]        rule_in_port_ff [ntt_pkg::RULE_SLOTS];
   logic               rule_we;
   logic [ntt_pkg::RULE_W-1:0] rule_wr_idx;

   logic               tbl_we;
   logic [IW-1:0]      tbl_wr_addr;
   logic               key_we;
   ntt_pkg::key_type   key_wdata, key_rd;
   ntt_pkg::track_type track_wdata, track_rd;
   logic               pmap_we;
   logic [WW-1:0]      pmap_wr_addr, pmap_rd_addr;
   logic [WB-1:0]      pmap_wdata, pmap_rd;

   logic [31:0]        ra;
   logic [15:0]        rp;
   logic               key_match;
   logic               rule_hit;
   logic [ntt_pkg::RULE_W-1:0] rule_idx;
   logic [WB-1:0]      avail;
   logic [BW-1:0]      bit_sel;
   ntt_pkg::key_type   cr_key, fwd_key;
   ntt_pkg::track_type trk_new;
   ntt_pkg::rsp_type   fwd_res, icmp_res, done_res;
   logic               expire;
   logic [WB-1:0]      port_mask;

   ntt_ram #(.WIDTH($bits(ntt_pkg::key_type)), .DEPTH(N)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(tbl_wr_addr), .wr_data(key_wdata),
      .rd_addr(idx_ff[IW-1:0]), .rd_data(key_rd)
   );
   ntt_ram #(.WIDTH($bits(ntt_pkg::track_type)), .DEPTH(N)) u_track_ram (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_wr_addr), .wr_data(track_wdata),
      .rd_addr(idx_ff[IW-1:0]), .rd_data(track_rd)
   );
   ntt_ram #(.WIDTH(WB), .DEPTH(ntt_pkg::PORT_WORDS)) u_port_ram (
      .clock(clock), .wr_en(pmap_we), .wr_addr(pmap_wr_addr), .wr_data(pmap_wdata),
      .rd_addr(pmap_rd_addr), .rd_data(pmap_rd)
   );

   // datapath
   always_comb begin
      ra = job_ff.inbound ? job_ff.src_addr : job_ff.dst_addr;
      rp = job_ff.inbound ? job_ff.src_port : job_ff.dst_port;
      key_match = (key_rd.remote_addr == ra) && (key_rd.peer_port == rp) &&
         (job_ff.inbound ?
            (key_rd.outside_addr == job_ff.dst_addr && key_rd.outside_port == job_ff.dst_port) :
            (key_rd.inside_addr == job_ff.src_addr && key_rd.inside_port == job_ff.src_port));

      rule_hit = 1'b0;
      rule_idx = '0;
      for (int r = ntt_pkg::RULE_SLOTS - 1; r >= 0; r--) begin
         if (rule_valid_ff[r] && rule_out_addr_ff[r] == job_ff.dst_addr &&
             rule_out_port_ff[r] == job_ff.dst_port) begin
            rule_hit = 1'b1;
            rule_idx = ntt_pkg::RULE_W'(r);
         end
      end

      for (int b = 0; b < WB; b++) begin
         avail[b] = !pmap_rd[b] &&
            (word_ff != cfg.port_low[PB-1:BW] || BW'(b) >= cfg.port_low[BW-1:0]) &&
            (word_ff != cfg.port_high[PB-1:BW] || BW'(b) <= cfg.port_high[BW-1:0]);
      end
      bit_sel = '0;
      for (int b = WB - 1; b >= 0; b--) begin
         if (avail[b]) bit_sel = BW'(b);
      end

      cr_key.remote_addr = ra;
      cr_key.peer_port = rp;
      if (job_ff.inbound) begin
         cr_key.outside_addr = rule_out_addr_ff[rule_idx];
         cr_key.outside_port = rule_out_port_ff[rule_idx];
         cr_key.inside_addr = rule_in_addr_ff[rule_idx];
         cr_key.inside_port = rule_in_port_ff[rule_idx];
      end else begin
         cr_key.outside_addr = cfg.external_address;
         cr_key.outside_port = {word_ff, bit_sel};
         cr_key.inside_addr = job_ff.src_addr;
         cr_key.inside_port = job_ff.src_port;
      end
      fwd_key = (state_ff == ntt_pkg::ST_SCAN) ? key_rd : cr_key;

      fwd_res.action = ntt_pkg::ACT_FORWARD;
      if (job_ff.inbound) begin
         fwd_res.out_src_addr = job_ff.src_addr;
         fwd_res.out_dst_addr = fwd_key.inside_addr;
         fwd_res.out_src_port = job_ff.src_port;
         fwd_res.out_dst_port = fwd_key.inside_port;
      end else begin
         fwd_res.out_src_addr = fwd_key.outside_addr;
         fwd_res.out_dst_addr = job_ff.dst_addr;
         fwd_res.out_src_port = fwd_key.outside_port;
         fwd_res.out_dst_port = job_ff.dst_port;
      end
      icmp_res = '0;
      icmp_res.action = ntt_pkg::ACT_ICMP;
      done_res = '0;
      done_res.action = ntt_pkg::ACT_DONE;

      trk_new = (state_ff == ntt_pkg::ST_SCAN) ? track_rd : '0;
      if (job_ff.inbound) begin
         if (job_ff.tcp_flags[ntt_pkg::FLAG_FIN]) trk_new.fin_bits[1] = 1'b1;
         trk_new.outside_seq_end = job_ff.seq_end;
         if (job_ff.tcp_flags[ntt_pkg::FLAG_ACK]) trk_new.outside_ack = job_ff.ack_number;
      end else begin
         if (job_ff.tcp_flags[ntt_pkg::FLAG_FIN]) trk_new.fin_bits[0] = 1'b1;
         trk_new.inside_seq_end = job_ff.seq_end;
         if (job_ff.tcp_flags[ntt_pkg::FLAG_ACK]) trk_new.inside_ack = job_ff.ack_number;
      end
      trk_new.last_seen = seconds_ff;

      expire = ((seconds_ff - track_rd.last_seen) > {16'd0, cfg.idle_timeout}) ||
         (track_rd.fin_bits == 2'b11 &&
          track_rd.inside_ack >= track_rd.outside_seq_end &&
          track_rd.outside_ack >= track_rd.inside_seq_end);

      port_mask = WB'(1) << port_ff[BW-1:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      idx_in = idx_ff;
      cmp_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      port_in = port_ff;
      set_in = set_ff;
      word_in = word_ff;
      clr_in = clr_ff;
      res_in = res_ff;
      valid_in = valid_ff;
      seconds_in = seconds_ff;
      rule_valid_in = rule_valid_ff;
      rule_we = 1'b0;
      rule_wr_idx = job_ff.rule_slot[ntt_pkg::RULE_W-1:0];
      q_pop = 1'b0;
      tbl_we = 1'b0;
      key_we = 1'b0;
      tbl_wr_addr = free_idx_ff;
      key_wdata = cr_key;
      track_wdata = trk_new;
      pmap_we = 1'b0;
      pmap_wr_addr = port_ff[PB-1:BW];
      pmap_wdata = set_ff ? (pmap_rd | port_mask) : (pmap_rd & ~port_mask);
      pmap_rd_addr = word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      unique case (state_ff)
         ntt_pkg::ST_CLEAR: begin
            pmap_we = 1'b1;
            pmap_wr_addr = clr_ff;
            pmap_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == WW'(ntt_pkg::PORT_WORDS - 1)) state_in = ntt_pkg::ST_IDLE;
         end
         ntt_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               job_in = q_job;
               idx_in = '0;
               free_in = 1'b0;
               state_in = ntt_pkg::ST_RESULT;
               res_in = done_res;
               unique case (q_job.kind)
                  ntt_pkg::KIND_ICMP: res_in = icmp_res;
                  ntt_pkg::KIND_DROP: begin
                     res_in = '0;
                     res_in.action = ntt_pkg::ACT_DROP;
                  end
                  ntt_pkg::KIND_TICK: begin
                     seconds_in = seconds_ff + 32'd1;
                     state_in = ntt_pkg::ST_TICK_RD;
                  end
                  ntt_pkg::KIND_RULE: begin
                     if (32'(q_job.rule_slot) < ntt_pkg::RULE_SLOTS) begin
                        rule_we = 1'b1;
                        rule_wr_idx = q_job.rule_slot[ntt_pkg::RULE_W-1:0];
                        rule_valid_in[rule_wr_idx] = 1'b1;
                        port_in = q_job.dst_port;
                        set_in = 1'b1;
                        state_in = ntt_pkg::ST_PORT_RD;
                     end
                  end
                  ntt_pkg::KIND_PKT: state_in = ntt_pkg::ST_SCAN;
                  default: res_in = done_res;
               endcase
            end
         end
         ntt_pkg::ST_SCAN: begin
            if (idx_ff < (IW+1)'(N)) begin
               idx_in = idx_ff + 1'b1;
               cmp_in = 1'b1;
               cmp_idx_in = idx_ff[IW-1:0];
            end
            if (cmp_ff) begin
               if (!valid_ff[cmp_idx_ff]) begin
                  if (!free_ff) begin
                     free_in = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == IW'(N - 1)) state_in = ntt_pkg::ST_MISS;
               end else if (key_match) begin
                  tbl_we = 1'b1;
                  tbl_wr_addr = cmp_idx_ff;
                  res_in = fwd_res;
                  state_in = ntt_pkg::ST_RESULT;
                  if (job_ff.tcp_flags[ntt_pkg::FLAG_RST]) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     port_in = key_rd.outside_port;
                     set_in = 1'b0;
                     state_in = ntt_pkg::ST_PORT_RD;
                  end
               end else if (cmp_idx_ff == IW'(N - 1)) begin
                  state_in = ntt_pkg::ST_MISS;
               end
            end
         end
         ntt_pkg::ST_MISS: begin
            res_in = icmp_res;
            state_in = ntt_pkg::ST_RESULT;
            if (job_ff.tcp_flags[ntt_pkg::FLAG_SYN] && free_ff) begin
               if (job_ff.inbound) begin
                  if (rule_hit) begin
                     key_we = 1'b1;
                     tbl_we = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     res_in = fwd_res;
                  end
               end else if (cfg.port_low <= cfg.port_high) begin
                  word_in = cfg.port_low[PB-1:BW];
                  state_in = ntt_pkg::ST_PSCAN_RD;
               end
            end
         end
         ntt_pkg::ST_PSCAN_RD: begin
            state_in = ntt_pkg::ST_PSCAN_EV;
         end
         ntt_pkg::ST_PSCAN_EV: begin
            if (|avail) begin
               key_we = 1'b1;
               tbl_we = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
               pmap_we = 1'b1;
               pmap_wr_addr = word_ff;
               pmap_wdata = pmap_rd | (WB'(1) << bit_sel);
               res_in = fwd_res;
               state_in = ntt_pkg::ST_RESULT;
            end else if (word_ff == cfg.port_high[PB-1:BW]) begin
               res_in = icmp_res;
               state_in = ntt_pkg::ST_RESULT;
            end else begin
               word_in = word_ff + 1'b1;
               state_in = ntt_pkg::ST_PSCAN_RD;
            end
         end
         ntt_pkg::ST_PORT_RD: begin
            pmap_rd_addr = port_ff[PB-1:BW];
            state_in = ntt_pkg::ST_PORT_WR;
         end
         ntt_pkg::ST_PORT_WR: begin
            pmap_we = 1'b1;
            state_in = (job_ff.kind == ntt_pkg::KIND_TICK) ?
               ntt_pkg::ST_TICK_RD : ntt_pkg::ST_RESULT;
         end
         ntt_pkg::ST_TICK_RD: begin
            if (idx_ff == (IW+1)'(N)) begin
               res_in = done_res;
               state_in = ntt_pkg::ST_RESULT;
            end else begin
               cmp_idx_in = idx_ff[IW-1:0];
               idx_in = idx_ff + 1'b1;
               state_in = ntt_pkg::ST_TICK_EV;
            end
         end
         ntt_pkg::ST_TICK_EV: begin
            state_in = ntt_pkg::ST_TICK_RD;
            if (valid_ff[cmp_idx_ff] && expire) begin
               valid_in[cmp_idx_ff] = 1'b0;
               port_in = key_rd.outside_port;
               set_in = 1'b0;
               state_in = ntt_pkg::ST_PORT_RD;
            end
         end
         ntt_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = ntt_pkg::ST_IDLE;
            end
         end
         default: state_in = ntt_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign status.clearing = (state_ff == ntt_pkg::ST_CLEAR);
   assign status.busy = (state_ff != ntt_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      cmp_idx_ff <= cmp_idx_in;
      free_idx_ff <= free_idx_in;
      port_ff <= port_in;
      set_ff <= set_in;
      word_ff <= word_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (rule_we) begin
         rule_out_addr_ff[rule_wr_idx] <= job_in.dst_addr;
         rule_out_port_ff[rule_wr_idx] <= job_in.dst_port;
         rule_in_addr_ff[rule_wr_idx] <= job_in.src_addr;
         rule_in_port_ff[rule_wr_idx] <= job_in.src_port;
      end
      if (reset) begin
         state_ff <= ntt_pkg::ST_CLEAR;
         idx_ff <= '0;
         cmp_ff <= 1'b0;
         free_ff <= 1'b0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
         seconds_ff <= '0;
         rule_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cmp_ff <= cmp_in;
         free_ff <= free_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff <= valid_in;
         seconds_ff <= seconds_in;
         rule_valid_ff <= rule_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: sim/ntt_checker.sv
`timescale 1ns / 1ps
// Checker of the TCP NAT translation table: watches request, response and config ports.
// Keeps its own copy of the table, predicts each response and counts mismatches.
// Depends on ntt_pkg.
module ntt_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ntt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ntt_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic             pready,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output int               error_count,
   output int               pending
);
   ntt_pkg::cfg_type   cfg;
   logic               flow_valid [ntt_pkg::TABLE_ENTRIES];
   ntt_pkg::key_type   flow_key [ntt_pkg::TABLE_ENTRIES];
   ntt_pkg::track_type flow_trk [ntt_pkg::TABLE_ENTRIES];
   logic               port_used [65536];
   logic               rule_valid [ntt_pkg::RULE_SLOTS];
   logic [31:0]        rule_out_addr [ntt_pkg::RULE_SLOTS];
   logic [15:0]        rule_out_port [ntt_pkg::RULE_SLOTS];
   logic [31:0]        rule_in_addr [ntt_pkg::RULE_SLOTS];
   logic [15:0]        rule_in_port [ntt_pkg::RULE_SLOTS];
   logic [31:0]        seconds;
   ntt_pkg::rsp_type   expected_q [$];

   function automatic void release_flow(input int i);
      port_used[flow_key[i].outside_port] = 1'b0;
      flow_valid[i] = 1'b0;
   endfunction

   function automatic void note_segment(input int i, input logic inbound,
         input ntt_pkg::req_type r);
      if (inbound) begin
         if (r.tcp_flags[ntt_pkg::FLAG_FIN]) flow_trk[i].fin_bits[1] = 1'b1;
         flow_trk[i].outside_seq_end = r.seq_end;
         if (r.tcp_flags[ntt_pkg::FLAG_ACK]) flow_trk[i].outside_ack = r.ack_number;
      end else begin
         if (r.tcp_flags[ntt_pkg::FLAG_FIN]) flow_trk[i].fin_bits[0] = 1'b1;
         flow_trk[i].inside_seq_end = r.seq_end;
         if (r.tcp_flags[ntt_pkg::FLAG_ACK]) flow_trk[i].inside_ack = r.ack_number;
      end
      flow_trk[i].last_seen = seconds;
   endfunction

   function automatic ntt_pkg::rsp_type translated(input int i, input logic inbound,
         input ntt_pkg::req_type r);
      ntt_pkg::rsp_type res;
      res.action = ntt_pkg::ACT_FORWARD;
      if (inbound) begin
         res.out_src_addr = r.src_addr;
         res.out_dst_addr = flow_key[i].inside_addr;
         res.out_src_port = r.src_port;
         res.out_dst_port = flow_key[i].inside_port;
      end else begin
         res.out_src_addr = flow_key[i].outside_addr;
         res.out_dst_addr = r.dst_addr;
         res.out_src_port = flow_key[i].outside_port;
         res.out_dst_port = r.dst_port;
      end
      return res;
   endfunction

   function automatic ntt_pkg::rsp_type napt_predict(input ntt_pkg::req_type r);
      ntt_pkg::rsp_type res;
      int               hit, free_idx, rule_hit, p;
      logic             inbound, found;
      logic [31:0]      ra;
      logic [15:0]      rp;
      res = '0;
      res.action = ntt_pkg::ACT_DONE;
      hit = -1;
      free_idx = -1;
      rule_hit = -1;
      found = 1'b0;
      if (r.op == ntt_pkg::OP_TICK) begin
         seconds = seconds + 32'd1;
         for (int i = 0; i < ntt_pkg::TABLE_ENTRIES; i++) begin
            if (flow_valid[i] && ((seconds - flow_trk[i].last_seen) > {16'd0, cfg.idle_timeout}
                  || (flow_trk[i].fin_bits == 2'b11
                      && flow_trk[i].inside_ack >= flow_trk[i].outside_seq_end
                      && flow_trk[i].outside_ack >= flow_trk[i].inside_seq_end)))
               release_flow(i);
         end
         return res;
      end
      if (r.op == ntt_pkg::OP_RULE) begin
         if (r.rule_slot < ntt_pkg::RULE_SLOTS) begin
            rule_valid[r.rule_slot] = 1'b1;
            rule_out_addr[r.rule_slot] = r.dst_addr;
            rule_out_port[r.rule_slot] = r.dst_port;
            rule_in_addr[r.rule_slot] = r.src_addr;
            rule_in_port[r.rule_slot] = r.src_port;
            port_used[r.dst_port] = 1'b1;
         end
         return res;
      end
      if (r.op == ntt_pkg::OP_NOP) return res;
      res.action = ntt_pkg::ACT_ICMP;
      if (r.direction != ntt_pkg::DIR_OUT && r.direction != ntt_pkg::DIR_IN) return res;
      if (!r.is_tcp) begin
         res.action = ntt_pkg::ACT_DROP;
         return res;
      end
      inbound = (r.direction == ntt_pkg::DIR_IN);
      ra = inbound ? r.src_addr : r.dst_addr;
      rp = inbound ? r.src_port : r.dst_port;
      for (int i = 0; i < ntt_pkg::TABLE_ENTRIES; i++) begin
         if (!flow_valid[i]) begin
            if (free_idx < 0) free_idx = i;
         end else if (hit < 0 && flow_key[i].remote_addr == ra && flow_key[i].peer_port == rp
               && (inbound ? (flow_key[i].outside_addr == r.dst_addr
                              && flow_key[i].outside_port == r.dst_port)
                           : (flow_key[i].inside_addr == r.src_addr
                              && flow_key[i].inside_port == r.src_port)))
            hit = i;
      end
      if (hit >= 0) begin
         note_segment(hit, inbound, r);
         res = translated(hit, inbound, r);
         if (r.tcp_flags[ntt_pkg::FLAG_RST]) release_flow(hit);
         return res;
      end
      if (!r.tcp_flags[ntt_pkg::FLAG_SYN] || free_idx < 0) return res;
      if (inbound) begin
         for (int i = 0; i < ntt_pkg::RULE_SLOTS; i++)
            if (rule_hit < 0 && rule_valid[i] && rule_out_addr[i] == r.dst_addr
                  && rule_out_port[i] == r.dst_port)
               rule_hit = i;
         if (rule_hit < 0) return res;
         flow_key[free_idx].outside_addr = rule_out_addr[rule_hit];
         flow_key[free_idx].outside_port = rule_out_port[rule_hit];
         flow_key[free_idx].inside_addr = rule_in_addr[rule_hit];
         flow_key[free_idx].inside_port = rule_in_port[rule_hit];
      end else begin
         for (p = int'(cfg.port_low); p <= int'(cfg.port_high); p++)
            if (!port_used[p]) begin
               found = 1'b1;
               break;
            end
         if (!found) return res;
         port_used[p] = 1'b1;
         flow_key[free_idx].outside_addr = cfg.external_address;
         flow_key[free_idx].outside_port = p[15:0];
         flow_key[free_idx].inside_addr = r.src_addr;
         flow_key[free_idx].inside_port = r.src_port;
      end
      flow_valid[free_idx] = 1'b1;
      flow_key[free_idx].remote_addr = ra;
      flow_key[free_idx].peer_port = rp;
      flow_trk[free_idx] = '0;
      note_segment(free_idx, inbound, r);
      return translated(free_idx, inbound, r);
   endfunction

   always @(posedge clock) begin
      ntt_pkg::rsp_type want;
      if (reset) begin
         cfg.external_address = ntt_pkg::RESET_EXT_ADDR;
         cfg.port_low = ntt_pkg::RESET_PORT_LOW;
         cfg.port_high = ntt_pkg::RESET_PORT_HIGH;
         cfg.idle_timeout = ntt_pkg::RESET_IDLE_TIMEOUT;
         for (int i = 0; i < ntt_pkg::TABLE_ENTRIES; i++) flow_valid[i] = 1'b0;
         for (int i = 0; i < 65536; i++) port_used[i] = 1'b0;
         for (int i = 0; i < ntt_pkg::RULE_SLOTS; i++) rule_valid[i] = 1'b0;
         seconds = '0;
         expected_q.delete();
         error_count <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (ntt_pkg::reg_type'(paddr[3:2]))
               ntt_pkg::REG_EXT_ADDR:     cfg.external_address = pwdata;
               ntt_pkg::REG_PORT_LOW:     cfg.port_low = pwdata[15:0];
               ntt_pkg::REG_PORT_HIGH:    cfg.port_high = pwdata[15:0];
               ntt_pkg::REG_IDLE_TIMEOUT: cfg.idle_timeout = pwdata[15:0];
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (error_count < 10) $display("unexpected response %p", rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.action !== rsp_data.action || want.out_src_addr !== rsp_data.out_src_addr
                     || want.out_dst_addr !== rsp_data.out_dst_addr
                     || want.out_src_port !== rsp_data.out_src_port
                     || want.out_dst_port !== rsp_data.out_dst_port) begin
                  if (error_count < 10)
                     $display("mismatch at %0t: expected %p, got %p", $realtime, want, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) expected_q.push_back(napt_predict(req_data));
         pending <= expected_q.size();
      end
   end
endmodule

// File: sim/tb_nat_tcp_translation_table.sv
`timescale 1ns / 1ps
// Testbench top of the TCP NAT translation table: clock, reset, requests, config writes.
// Depends on ntt_pkg, the block and ntt_checker, which predicts and compares.
module tb_nat_tcp_translation_table;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [31:0] RULE_ADDR = 32'hC6336401;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ntt_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ntt_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [3:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;
   int               error_count, pending, quiet_cycles;
   logic             gaps_on = 1'b1;
   logic             flood = 1'b0;
   logic [31:0]      cur_ext = ntt_pkg::RESET_EXT_ADDR;
   logic [15:0]      cur_low = ntt_pkg::RESET_PORT_LOW;

   nat_tcp_translation_table uut (.*);
   ntt_checker u_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) rsp_stall <= gaps_on && !reset && ($urandom_range(99) < 26);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   function automatic ntt_pkg::req_type mk(input logic [1:0] op, input logic [1:0] dir,
         input logic tcp, input logic [31:0] sa, input logic [31:0] da, input logic [15:0] sp,
         input logic [15:0] dp, input logic [3:0] flags, input logic [31:0] seq,
         input logic [31:0] ack, input logic [2:0] slot);
      return '{op, dir, tcp, sa, da, sp, dp, flags, seq, ack, slot};
   endfunction

   function automatic logic [3:0] pick_flags();
      logic [3:0] f;
      f = '0;
      f[ntt_pkg::FLAG_SYN] = $urandom_range(99) < 30;
      f[ntt_pkg::FLAG_ACK] = $urandom_range(99) < 70;
      f[ntt_pkg::FLAG_FIN] = $urandom_range(99) < 12;
      f[ntt_pkg::FLAG_RST] = $urandom_range(99) < 5;
      return f;
   endfunction

   function automatic ntt_pkg::req_type make_request();
      int          k;
      logic [31:0] host, remote, seq, ack;
      logic [15:0] hport, rport;
      k = $urandom_range(99);
      host = 32'h0A000001 + $urandom_range(3);
      hport = 16'(1000 + $urandom_range(3));
      remote = 32'hCB007101 + $urandom_range(3);
      rport = ($urandom_range(3) == 0) ? 16'hFFFF : 16'(80 + $urandom_range(2));
      seq = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20);
      ack = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20);
      if (flood) begin
         if (k < 80)
            return mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, $urandom, RULE_ADDR,
                      16'($urandom), 16'(8080 + $urandom_range(3)), 4'b0010, seq, ack, '0);
         k = $urandom_range(60, 99);
      end
      if (k < 40)
         return mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, host, remote, hport, rport,
                   pick_flags(), seq, ack, 3'($urandom));
      if (k < 60)
         return mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, remote, cur_ext, rport,
                   16'(cur_low + $urandom_range(7)), pick_flags(), seq, ack, 3'($urandom));
      if (k < 80)
         return mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, remote, RULE_ADDR, rport,
                   16'(8080 + $urandom_range(3)), pick_flags(), seq, ack, 3'($urandom));
      if (k < 88)
         return mk(ntt_pkg::OP_TICK, 2'($urandom), 1'($urandom), $urandom, $urandom,
                   16'($urandom), 16'($urandom), 4'($urandom), $urandom, $urandom,
                   3'($urandom));
      if (k < 92)
         return mk(ntt_pkg::OP_RULE, 2'($urandom), 1'($urandom),
                   32'h0A000101 + $urandom_range(1), RULE_ADDR, 16'd80,
                   16'(8080 + $urandom_range(3)), 4'($urandom), $urandom, $urandom,
                   3'($urandom_range(7)));
      return mk(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom), $urandom,
                $urandom, 16'($urandom), 16'($urandom), 4'($urandom), $urandom, $urandom,
                3'($urandom));
   endfunction

   task automatic send(input ntt_pkg::req_type r);
      if (gaps_on && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 26);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input ntt_pkg::reg_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [31:0] ext, input logic [15:0] lo,
         input logic [15:0] hi, input logic [15:0] timeout, input int count);
      drain();
      csr_write(ntt_pkg::REG_EXT_ADDR, ext);
      csr_write(ntt_pkg::REG_PORT_LOW, {16'd0, lo});
      csr_write(ntt_pkg::REG_PORT_HIGH, {16'd0, hi});
      csr_write(ntt_pkg::REG_IDLE_TIMEOUT, {16'd0, timeout});
      cur_ext = ext;
      cur_low = lo;
      repeat (count) send(make_request());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // load rules at the slot extremes, one claiming the first allocatable port
      send(mk(ntt_pkg::OP_RULE, ntt_pkg::DIR_OUT, 1'b0, 32'h0A000101, RULE_ADDR, 16'd80,
              16'd8080, '0, '0, '0, 3'd0));
      send(mk(ntt_pkg::OP_RULE, ntt_pkg::DIR_OUT, 1'b0, 32'hFFFFFFFF, 32'd0, 16'hFFFF,
              16'd12345, '0, '0, '0, 3'd7));
      send(mk(ntt_pkg::OP_NOP, ntt_pkg::DIR_OUT, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1));
      send(mk(ntt_pkg::OP_PACKET, 2'd2, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4, 4'b0010,
              '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, 2'd3, 1'b0, 32'd1, 32'd2, 16'd3, 16'd4, 4'b0010,
              '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b0, 32'd1, 32'd2, 16'd3, 16'd4,
              4'b0010, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4,
              4'b1000, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'd9, RULE_ADDR, 16'd5, 16'd9999,
              4'b0010, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'd0, 32'hFFFFFFFF, 16'd0,
              16'hFFFF, 4'b0010, 32'hFFFFFFFF, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'hFFFFFFFF, 32'd0, 16'hFFFF,
              16'd0, 4'b0110, 32'd5, 32'd7, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'hFFFFFFFF, 32'd0, 16'hFFFF,
              16'd12346, 4'b1001, 32'd0, 32'hFFFFFFFF, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'd0, 32'd0, 16'd0, 16'd12346,
              4'b1000, '0, '0, '0));
      // close a flow on both sides, then let a tick sweep it
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'd7, RULE_ADDR, 16'd7, 16'd8080,
              4'b0010, 32'd10, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'h0A000101, 32'd7, 16'd80,
              16'd7, 4'b1001, 32'd20, 32'd10, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'd7, RULE_ADDR, 16'd7, 16'd8080,
              4'b1001, 32'd10, 32'd20, '0));
      send(mk(ntt_pkg::OP_TICK, ntt_pkg::DIR_OUT, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_IN, 1'b1, 32'd7, RULE_ADDR, 16'd7, 16'd8080,
              4'b1000, '0, '0, '0));
      // reset on a matched flow forwards and then frees it
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4,
              4'b0010, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4,
              4'b0100, '0, '0, '0));
      send(mk(ntt_pkg::OP_PACKET, ntt_pkg::DIR_OUT, 1'b1, 32'd1, 32'd2, 16'd3, 16'd4,
              4'b1000, '0, '0, '0));
      run_phase(32'hC0A80001, 16'd1000, 16'd1007, 16'd3, 400);
      gaps_on = 1'b0;
      run_phase(32'hFFFFFFFF, 16'd0, 16'd65535, 16'd65535, 350);
      gaps_on = 1'b1;
      run_phase(32'd0, 16'd500, 16'd400, 16'd1, 350);
      run_phase($urandom, 16'd65530, 16'd65535, 16'd2, 350);
      flood = 1'b1;
      run_phase(32'h0A0A0A0A, 16'd2000, 16'd2003, 16'd65535, 350);
      drain();
      repeat (300) @(posedge clock);
      if (error_count == 0 && pending == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/ntt_pkg.sv
rtl/ntt_ram.sv
rtl/ntt_front.sv
rtl/ntt_engine.sv
rtl/nat_tcp_translation_table.sv
sim/ntt_checker.sv
sim/tb_nat_tcp_translation_table.sv
